/* rtl/core/ecft_pkg.sv */
// Package with the frame constants, slot type and CRC/escape helper functions.
package ecft_pkg;

    localparam logic [7:0]  MARK_START  = 8'hE1;
    localparam logic [7:0]  MARK_END    = 8'hE2;
    localparam logic [7:0]  ESC_BYTE    = 8'hFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [7:0]  BODY_LEN_LO = 8'h08;
    localparam logic [7:0]  BODY_LEN_HI = 8'h00;
    localparam int          BODY_LEN    = 8;

    // One slot per frame symbol: start mark, eight body bytes, end mark.
    localparam int SLOTS = BODY_LEN + 2;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // APB address map: one register, word aligned.
    localparam int         ADDR_W        = 3;
    localparam logic [0:0] REG_DEVICE_ID = 1'b0;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic       dbl;
    } slot_t;

    typedef slot_t [SLOTS-1:0] frame_t;

    typedef struct packed {
        logic [15:0] device_id;
        logic [15:0] crc_pre;
    } cfg_t;

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic slot_t escape_byte(logic [7:0] b);
        slot_t s;
        s.first  = b;
        s.second = 8'h00;
        s.dbl    = 1'b0;
        if (b == ESC_BYTE) begin
            s.first  = ESC_BYTE;
            s.second = ESC_BYTE;
            s.dbl    = 1'b1;
        end
        else if (b == MARK_START || b == MARK_END) begin
            s.first  = ESC_BYTE;
            s.second = b ^ ESC_BYTE;
            s.dbl    = 1'b1;
        end
        return s;
    endfunction

    // CRC after the two length bytes, which never change.
    localparam logic [15:0] CRC_SEED = crc_byte(crc_byte(16'h0000, BODY_LEN_LO), BODY_LEN_HI);
    // CRC after the length and a device id of zero.
    localparam logic [15:0] CRC_PRE_RESET = crc_byte(crc_byte(CRC_SEED, 8'h00), 8'h00);

endpackage

/* rtl/core/ecft_item_if.sv */
// Request channel carrying one reply request per transfer.
interface ecft_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_code;
    logic [7:0] status_byte;

    modport source (output valid, output reply_code, output status_byte, input ready);
    modport sink   (input valid, input reply_code, input status_byte, output ready);
endinterface

/* rtl/core/ecft_line_if.sv */
// Line channel carrying one escaped frame byte per transfer.
interface ecft_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;

    modport source (output valid, output tx_byte, output frame_end, input ready);
    modport sink   (input valid, input tx_byte, input frame_end, output ready);
endinterface

/* rtl/core/ecft_cfg_regs.sv */
// APB register block holding the device id and the CRC prefix over length and id.
module ecft_cfg_regs
    import ecft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [15:0] device_id_reg, device_id_next;
    logic [15:0] crc_pre_reg, crc_pre_next;
    logic        wr_id;

    assign pready = 1'b1;
    assign wr_id  = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_DEVICE_ID);

    // The prefix is updated together with the id so a request right after a write sees both.
    always_comb
    begin
        device_id_next = device_id_reg;
        crc_pre_next   = crc_pre_reg;
        if (wr_id)
        begin
            device_id_next = pwdata[15:0];
            crc_pre_next   = crc_byte(crc_byte(CRC_SEED, pwdata[7:0]), pwdata[15:8]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= 16'h0000;
            crc_pre_reg   <= CRC_PRE_RESET;
        end
        else
        begin
            device_id_reg <= device_id_next;
            crc_pre_reg   <= crc_pre_next;
        end
    end

    always_comb
    begin
        prdata = 32'h0000_0000;
        if (paddr[ADDR_W-1:2] == REG_DEVICE_ID)
        begin
            prdata = {16'h0000, device_id_reg};
        end
    end

    assign cfg.device_id = device_id_reg;
    assign cfg.crc_pre   = crc_pre_reg;

endmodule

/* rtl/core/ecft_framer.sv */
// Request register and frame builder: body, CRC and escape plan for one frame.
module ecft_framer
    import ecft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    ecft_item_if.sink item,
    input  cfg_t    cfg,
    input  logic    ser_free,
    output logic    load,
    output frame_t  frame
);

    logic        item_valid_reg, item_valid_next;
    logic [7:0]  reply_reg;
    logic [7:0]  status_reg;
    logic [15:0] crc;
    logic [7:0]  body [BODY_LEN];
    logic        accept;

    assign load       = item_valid_reg && ser_free;
    assign item.ready = !item_valid_reg || load;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (load)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            reply_reg  <= item.reply_code;
            status_reg <= item.status_byte;
        end
    end

    assign crc = crc_byte(crc_byte(cfg.crc_pre, reply_reg), status_reg);

    always_comb
    begin
        body[0] = BODY_LEN_LO;
        body[1] = BODY_LEN_HI;
        body[2] = cfg.device_id[7:0];
        body[3] = cfg.device_id[15:8];
        body[4] = reply_reg;
        body[5] = status_reg;
        body[6] = crc[7:0];
        body[7] = crc[15:8];
    end

    always_comb
    begin
        frame[0].first  = MARK_START;
        frame[0].second = 8'h00;
        frame[0].dbl    = 1'b0;
        for (int i = 0; i < BODY_LEN; i++)
        begin
            frame[i+1] = escape_byte(body[i]);
        end
        frame[SLOTS-1].first  = MARK_END;
        frame[SLOTS-1].second = 8'h00;
        frame[SLOTS-1].dbl    = 1'b0;
    end

endmodule

/* rtl/core/ecft_serializer.sv */
// Slot shift register that sends one line byte per cycle while line is ready, two bytes for an escaped slot.
module ecft_serializer
    import ecft_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  frame_t frame,
    output logic   ser_free,
    ecft_line_if.source line
);

    frame_t           slots_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             phase_reg, phase_next;
    logic             take;
    logic             advance;
    slot_t            cur;

    assign cur            = slots_reg[0];
    assign line.valid     = (cnt_reg != '0);
    assign line.tx_byte   = phase_reg ? cur.second : cur.first;
    assign line.frame_end = (cnt_reg == CNT_W'(1));
    assign take           = line.valid && line.ready;
    // A slot is done on its single byte, or on the second byte of an escape pair.
    assign advance        = take && (!cur.dbl || phase_reg);
    assign ser_free       = (cnt_reg == '0) || (advance && cnt_reg == CNT_W'(1));

    always_comb
    begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (load)
        begin
            cnt_next   = CNT_W'(SLOTS);
            phase_next = 1'b0;
        end
        else if (advance)
        begin
            cnt_next   = cnt_reg - CNT_W'(1);
            phase_next = 1'b0;
        end
        else if (take)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slots_reg <= frame;
        end
        else if (advance)
        begin
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                slots_reg[i] <= slots_reg[i+1];
            end
        end
    end

endmodule

/* rtl/core/escaped_crc_frame_transmitter.sv */
// Top level of the escaped reply-frame transmitter with CRC-16/KERMIT.
//
//   Channel   Direction  Payload                    Transfer
//   item      in         reply_code, status_byte    valid and ready high at clk
//   line      out        tx_byte, frame_end         valid and ready high at clk
//   APB       in/out     device_id at address 0     psel, penable, pwrite, pready
//
// Each request yields one frame of 10 to 16 line bytes (10 plus one for every escaped body
// byte), one byte per cycle while line is ready; the slot shift register in the serializer
// sets that pace. The next frame loads on the edge that takes the last byte, so frames follow
// with no gap, and one further request waits in the request register meanwhile.
// Reset clears the device id and empties both stages. A stall on line holds the current
// byte; item stays ready until the request register holds a request the serializer can't take.
module escaped_crc_frame_transmitter
    import ecft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    ecft_item_if.sink         item,
    ecft_line_if.source       line
);

    cfg_t   cfg;
    logic   ser_free;
    logic   load;
    frame_t frame;

    ecft_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ecft_framer u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg      (cfg),
        .ser_free (ser_free),
        .load     (load),
        .frame    (frame)
    );

    ecft_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .frame    (frame),
        .ser_free (ser_free),
        .line     (line)
    );

endmodule

/* rtl/core/ecft_checker.sv */
// Port-level checker for the frame transmitter, bound to the top level.
module ecft_checker
    import ecft_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       line_valid,
    input logic       line_ready,
    input logic [7:0] line_tx_byte,
    input logic       line_frame_end
);

    // The end mark is the last byte of a frame.
    a_end_is_mark: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && line_frame_end |-> line_tx_byte == MARK_END)
        else $error("frame_end on a byte other than the end mark");

    // Escaping keeps a raw end mark out of the body.
    a_mark_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && line_tx_byte == MARK_END |-> line_frame_end)
        else $error("unescaped end mark inside a frame body");

    // A frame that follows directly after another opens with the start mark.
    a_start_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && line_ready && line_frame_end ##1 line_valid
        |-> line_tx_byte == MARK_START)
        else $error("frame does not open with the start mark");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && !line_ready
        |=> line_valid && $stable(line_tx_byte) && $stable(line_frame_end))
        else $error("line byte changed while stalled");

endmodule

bind escaped_crc_frame_transmitter ecft_checker u_ecft_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .line_valid     (line.valid),
    .line_ready     (line.ready),
    .line_tx_byte   (line.tx_byte),
    .line_frame_end (line.frame_end)
);
